>>> rtl/prit_pkg.sv
// shared constants and types for the pending request id tracker
`timescale 1ns / 1ps

package prit_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 8;
    localparam int ID_W        = 32;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int COUNT_W     = 4;

    // opcodes
    localparam logic OP_ISSUE = 1'b0;
    localparam logic OP_ACK   = 1'b1;

    // control broadcast to every cell of the table
    typedef struct packed {
        logic            issue;
        logic            ack;
        logic            full;
        logic [ID_W-1:0] id;
    } prit_ctrl_t;

endpackage

>>> rtl/prit_cell.sv
// one slot of the id table: holds an entry, compares it and shifts from its upper neighbour
`timescale 1ns / 1ps

module prit_cell (
    input  logic                     aclk,
    input  prit_pkg::prit_ctrl_t     ctrl,
    input  logic                     occupied,
    input  logic                     tail,
    input  logic [prit_pkg::ID_W-1:0] next_entry,
    input  logic                     found_in,
    output logic                     found_out,
    output logic [prit_pkg::ID_W-1:0] entry
);
    import prit_pkg::*;

    logic [ID_W-1:0] entry_reg;
    logic [ID_W-1:0] entry_next;
    logic            hit;
    logic            take_next;

    // first match search ripples along the chain
    assign hit       = ctrl.ack && occupied && (entry_reg == ctrl.id);
    assign found_out = found_in || hit;

    // shift down on a full issue, or at and behind the matched slot on acknowledge
    assign take_next = (ctrl.issue && ctrl.full) || (ctrl.ack && found_out);

    always_comb begin
        entry_next = entry_reg;
        if (take_next) begin
            entry_next = next_entry;
        end else if (ctrl.issue && tail) begin
            entry_next = ctrl.id;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> rtl/pending_request_id_tracker_top.sv
// top level of the pending request id tracker: cell chain, fill count, id counter, output register
`timescale 1ns / 1ps

// Keeps the ids of outstanding requests, oldest first, in a chain of TABLE_DEPTH cells.
// An issue beat appends its id (an id of zero takes the next value of a counter that
// runs 1, 2, ... and skips zero on wrap); on a full table the oldest id drops out and
// evicted is set. An acknowledge beat removes the oldest matching id and closes the gap;
// matched tells whether one was found. Every beat gives exactly one result beat, in the
// cycle after it is taken. One beat is taken per cycle while the result register is
// free or being emptied; the cycle time is set by the match search rippling through
// the cell chain, whose length is TABLE_DEPTH.
module pending_request_id_tracker_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [prit_pkg::ID_W-1:0]     s_request_id,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [prit_pkg::ID_W-1:0]     m_used_id,
    output logic [prit_pkg::COUNT_W-1:0]  m_pending_count,
    output logic                          m_matched,
    output logic                          m_evicted
);
    import prit_pkg::*;

    logic             accept;
    logic             full;
    logic [ID_W-1:0]  used_id;
    prit_ctrl_t       ctrl;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [ID_W-1:0]  auto_id_reg;
    logic [ID_W-1:0]  auto_id_next;
    logic [ID_W-1:0]  auto_id_inc;

    logic             m_valid_reg;
    logic [ID_W-1:0]  used_id_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             matched_reg;
    logic             evicted_reg;

    logic [ID_W-1:0]  entry_w [TABLE_DEPTH];
    logic             found_w [TABLE_DEPTH+1];

    // handshake: take a beat when the result register is empty or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign used_id = ((s_opcode == OP_ISSUE) && (s_request_id == '0)) ? auto_id_reg
                                                                      : s_request_id;

    assign ctrl.issue = accept && (s_opcode == OP_ISSUE);
    assign ctrl.ack   = accept && (s_opcode == OP_ACK);
    assign ctrl.full  = full;
    assign ctrl.id    = used_id;

    // chain of cells
    assign found_w[0] = 1'b0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic [ID_W-1:0] upper;
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign upper = used_id;
        end else begin : g_mid
            assign upper = entry_w[g+1];
        end

        prit_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occupied   (count_reg > CNT_W'(g)),
            .tail       (count_reg == CNT_W'(g)),
            .next_entry (upper),
            .found_in   (found_w[g]),
            .found_out  (found_w[g+1]),
            .entry      (entry_w[g])
        );
    end

    // fill count
    always_comb begin
        count_next = count_reg;
        if (ctrl.issue && !full) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.ack && found_w[TABLE_DEPTH]) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // automatic id counter, skips zero on wrap
    assign auto_id_inc = auto_id_reg + ID_W'(1);

    always_comb begin
        auto_id_next = auto_id_reg;
        if (ctrl.issue && (s_request_id == '0)) begin
            auto_id_next = (auto_id_inc == '0) ? ID_W'(1) : auto_id_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            auto_id_reg <= ID_W'(1);
        end else begin
            count_reg   <= count_next;
            auto_id_reg <= auto_id_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            used_id_reg   <= used_id;
            out_count_reg <= count_next;
            matched_reg   <= ctrl.ack && found_w[TABLE_DEPTH];
            evicted_reg   <= ctrl.issue && full;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_used_id       = used_id_reg;
    assign m_pending_count = COUNT_W'(out_count_reg);
    assign m_matched       = matched_reg;
    assign m_evicted       = evicted_reg;

endmodule
